// ===== rtl/core/salsa20_pkg.sv =====
// Shared types, constants and helper functions of the Salsa20 stream cipher.
package salsa20_pkg;

   localparam int WORD_W      = 32;
   localparam int NUM_WORDS   = 16;
   localparam int WORD_IDX_W  = $clog2(NUM_WORDS);
   localparam int BYTE_W      = 8;
   localparam int POS_W       = 6;
   localparam int COUNTER_W   = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int NUM_QROUNDS = 8;
   localparam int QR_IDX_W    = $clog2(NUM_QROUNDS);
   localparam int NUM_DROUNDS = 10;
   localparam int DROUND_W    = $clog2(NUM_DROUNDS);
   localparam int FEED_W      = WORD_IDX_W + 1;

   localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_7   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_8_15  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_16_23 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_24_31 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE     = 3'd4;

   localparam int ROT_A = 7;
   localparam int ROT_B = 9;
   localparam int ROT_C = 13;
   localparam int ROT_D = 18;

   // Word indexes of each quarter round, addressed by {quarter round, role a/b/c/d}.
   localparam logic [WORD_IDX_W-1:0] QR_TABLE [NUM_QROUNDS*4] = '{
      4'd0,  4'd4,  4'd8,  4'd12,
      4'd5,  4'd9,  4'd13, 4'd1,
      4'd10, 4'd14, 4'd2,  4'd6,
      4'd15, 4'd3,  4'd7,  4'd11,
      4'd0,  4'd1,  4'd2,  4'd3,
      4'd5,  4'd6,  4'd7,  4'd4,
      4'd10, 4'd11, 4'd8,  4'd9,
      4'd15, 4'd12, 4'd13, 4'd14
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      GEN_IDLE,
      GEN_INIT,
      GEN_READ_AB,
      GEN_READ_CD,
      GEN_LOAD_CD,
      GEN_STEP,
      GEN_FEED
   } gen_state_type;

   typedef struct packed {
      logic       load_ab;
      logic       load_cd;
      logic       step_en;
      logic [1:0] step_sel;
   } step_ctrl_type;

   function automatic logic [WORD_W-1:0] rotl_step(input logic [WORD_W-1:0] v,
                                                    input logic [1:0]        sel);
      logic [WORD_W-1:0] r;
      case (sel)
         2'd0: r = (v << ROT_A) | (v >> (WORD_W - ROT_A));
         2'd1: r = (v << ROT_B) | (v >> (WORD_W - ROT_B));
         2'd2: r = (v << ROT_C) | (v >> (WORD_W - ROT_C));
         2'd3: r = (v << ROT_D) | (v >> (WORD_W - ROT_D));
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/salsa20_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module salsa20_ram #(
   parameter int WIDTH = salsa20_pkg::WORD_W,
   parameter int DEPTH = salsa20_pkg::NUM_WORDS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// ===== rtl/core/salsa20_step.sv =====
// Shared quarter-round step unit: four working words and one add, rotate and XOR.
module salsa20_step (
   input  logic                            clock,
   input  salsa20_pkg::step_ctrl_type      ctrl,
   input  logic [salsa20_pkg::WORD_W-1:0]  rd_data0,
   input  logic [salsa20_pkg::WORD_W-1:0]  rd_data1,
   output logic [salsa20_pkg::WORD_W-1:0]  step_word
);

   logic [salsa20_pkg::WORD_W-1:0] q_ff [4];
   logic [salsa20_pkg::WORD_W-1:0] q_in [4];

   // The target always sits in slot 1; the queue rotates after each step so that
   // the four steps of a quarter round use the same datapath.
   assign step_word = q_ff[1] ^ salsa20_pkg::rotl_step(q_ff[0] + q_ff[3], ctrl.step_sel);

   always_comb begin
      q_in = q_ff;
      if (ctrl.load_ab) begin
         q_in[0] = rd_data0;
         q_in[1] = rd_data1;
      end
      if (ctrl.load_cd) begin
         q_in[2] = rd_data0;
         q_in[3] = rd_data1;
      end
      if (ctrl.step_en) begin
         q_in[0] = step_word;
         q_in[1] = q_ff[2];
         q_in[2] = q_ff[3];
         q_in[3] = q_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

// ===== rtl/core/salsa20_blockgen.sv =====
// Keystream block generator: sequencer, round-word RAM, step unit and keystream registers.
module salsa20_blockgen (
   input  logic                                                  clock,
   input  logic                                                  reset,
   input  logic                                                  gen_start,
   input  logic [salsa20_pkg::NUM_WORDS-1:0][salsa20_pkg::WORD_W-1:0] init_words,
   output logic                                                  gen_done,
   output logic [salsa20_pkg::NUM_WORDS-1:0][salsa20_pkg::WORD_W-1:0] ks_words
);

   localparam logic [salsa20_pkg::WORD_IDX_W-1:0] LAST_WORD =
      salsa20_pkg::WORD_IDX_W'(salsa20_pkg::NUM_WORDS - 1);
   localparam logic [salsa20_pkg::QR_IDX_W-1:0] LAST_QR =
      salsa20_pkg::QR_IDX_W'(salsa20_pkg::NUM_QROUNDS - 1);
   localparam logic [salsa20_pkg::DROUND_W-1:0] LAST_DROUND =
      salsa20_pkg::DROUND_W'(salsa20_pkg::NUM_DROUNDS - 1);
   localparam logic [salsa20_pkg::FEED_W-1:0] FEED_END =
      salsa20_pkg::FEED_W'(salsa20_pkg::NUM_WORDS);

   salsa20_pkg::gen_state_type state_ff;
   salsa20_pkg::gen_state_type state_in;

   logic [salsa20_pkg::WORD_IDX_W-1:0] init_cnt_ff, init_cnt_in;
   logic [salsa20_pkg::QR_IDX_W-1:0]   qr_ff, qr_in;
   logic [salsa20_pkg::DROUND_W-1:0]   dround_ff, dround_in;
   logic [1:0]                         step_ff, step_in;
   logic [salsa20_pkg::FEED_W-1:0]     feed_ff, feed_in;

   logic                               wr_en;
   logic [salsa20_pkg::WORD_IDX_W-1:0] wr_addr;
   logic [salsa20_pkg::WORD_W-1:0]     wr_data;
   logic [salsa20_pkg::WORD_IDX_W-1:0] rd_addr0;
   logic [salsa20_pkg::WORD_IDX_W-1:0] rd_addr1;
   logic [salsa20_pkg::WORD_W-1:0]     rd_data0;
   logic [salsa20_pkg::WORD_W-1:0]     rd_data1;
   logic [salsa20_pkg::WORD_W-1:0]     step_word;
   salsa20_pkg::step_ctrl_type         step_ctrl;
   logic                               ks_wr;
   logic [salsa20_pkg::WORD_IDX_W-1:0] feed_prev;
   logic [1:0]                         step_next;

   logic [salsa20_pkg::NUM_WORDS-1:0][salsa20_pkg::WORD_W-1:0] ks_ff;

   assign feed_prev = feed_ff[salsa20_pkg::WORD_IDX_W-1:0] - 1'b1;
   assign step_next = step_ff + 2'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salsa20_pkg::GEN_IDLE: begin
            if (gen_start) begin
               state_in = salsa20_pkg::GEN_INIT;
            end
         end
         salsa20_pkg::GEN_INIT: begin
            if (init_cnt_ff == LAST_WORD) begin
               state_in = salsa20_pkg::GEN_READ_AB;
            end
         end
         salsa20_pkg::GEN_READ_AB: state_in = salsa20_pkg::GEN_READ_CD;
         salsa20_pkg::GEN_READ_CD: state_in = salsa20_pkg::GEN_LOAD_CD;
         salsa20_pkg::GEN_LOAD_CD: state_in = salsa20_pkg::GEN_STEP;
         salsa20_pkg::GEN_STEP: begin
            if (step_ff == 2'd3) begin
               if (qr_ff == LAST_QR && dround_ff == LAST_DROUND) begin
                  state_in = salsa20_pkg::GEN_FEED;
               end else begin
                  state_in = salsa20_pkg::GEN_READ_AB;
               end
            end
         end
         salsa20_pkg::GEN_FEED: begin
            if (feed_ff == FEED_END) begin
               state_in = salsa20_pkg::GEN_IDLE;
            end
         end
         default: state_in = salsa20_pkg::GEN_IDLE;
      endcase
   end

   always_comb begin
      init_cnt_in = init_cnt_ff;
      qr_in       = qr_ff;
      dround_in   = dround_ff;
      step_in     = step_ff;
      feed_in     = feed_ff;
      case (state_ff)
         salsa20_pkg::GEN_IDLE: begin
            init_cnt_in = '0;
            qr_in       = '0;
            dround_in   = '0;
            step_in     = '0;
            feed_in     = '0;
         end
         salsa20_pkg::GEN_INIT: init_cnt_in = init_cnt_ff + 1'b1;
         salsa20_pkg::GEN_STEP: begin
            step_in = step_next;
            if (step_ff == 2'd3) begin
               qr_in = qr_ff + 1'b1;
               if (qr_ff == LAST_QR) begin
                  dround_in = dround_ff + 1'b1;
               end
            end
         end
         salsa20_pkg::GEN_FEED: feed_in = feed_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = init_cnt_ff;
      wr_data   = init_words[init_cnt_ff];
      rd_addr0  = salsa20_pkg::QR_TABLE[{qr_ff, 2'd0}];
      rd_addr1  = salsa20_pkg::QR_TABLE[{qr_ff, 2'd1}];
      step_ctrl = '{load_ab: 1'b0, load_cd: 1'b0, step_en: 1'b0, step_sel: step_ff};
      ks_wr     = 1'b0;
      gen_done  = 1'b0;
      case (state_ff)
         salsa20_pkg::GEN_INIT: wr_en = 1'b1;
         salsa20_pkg::GEN_READ_CD: begin
            rd_addr0          = salsa20_pkg::QR_TABLE[{qr_ff, 2'd2}];
            rd_addr1          = salsa20_pkg::QR_TABLE[{qr_ff, 2'd3}];
            step_ctrl.load_ab = 1'b1;
         end
         salsa20_pkg::GEN_LOAD_CD: step_ctrl.load_cd = 1'b1;
         salsa20_pkg::GEN_STEP: begin
            step_ctrl.step_en = 1'b1;
            wr_en             = 1'b1;
            wr_addr           = salsa20_pkg::QR_TABLE[{qr_ff, step_next}];
            wr_data           = step_word;
         end
         salsa20_pkg::GEN_FEED: begin
            rd_addr0 = feed_ff[salsa20_pkg::WORD_IDX_W-1:0];
            ks_wr    = (feed_ff != '0);
            gen_done = (feed_ff == FEED_END);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= salsa20_pkg::GEN_IDLE;
      end else begin
         state_ff <= state_in;
      end
      init_cnt_ff <= init_cnt_in;
      qr_ff       <= qr_in;
      dround_ff   <= dround_in;
      step_ff     <= step_in;
      feed_ff     <= feed_in;
      if (ks_wr) begin
         ks_ff[feed_prev] <= rd_data0 + init_words[feed_prev];
      end
   end

   assign ks_words = ks_ff;

   salsa20_ram #(
      .WIDTH (salsa20_pkg::WORD_W),
      .DEPTH (salsa20_pkg::NUM_WORDS)
   ) u_round_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   salsa20_step u_step (
      .clock     (clock),
      .ctrl      (step_ctrl),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1),
      .step_word (step_word)
   );

endmodule

// ===== rtl/core/salsa20_stream_cipher.sv =====
// Top level of the Salsa20/20 byte stream cipher: configuration, byte path and result register.
//
// Channel   Direction  Handshake             Beat contents
// req       in         req_valid/req_stall   req_msg_byte, req_start_req
// rsp       out        rsp_valid/rsp_stall   rsp_out_byte
// csr       in         csr_wr_en             csr_index, csr_wdata
//
// A byte inside a keystream block is accepted in any cycle in which the result register is free.
// A byte at a block boundary passes, from its accept to the next one, through the accepting
// cycle, the loading of the 16 state words into the round RAM, the 80 quarter rounds on the shared
// step unit (read a/b, read c/d, load c/d, then four steps each), the feed-forward and the result register.
// Reset clears the key, nonce, position and block counter; the keystream holds no reset value.
// The req side stalls while a block is generated or output, or while an unread result is stalled.
module salsa20_stream_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [salsa20_pkg::BYTE_W-1:0]      req_msg_byte,
   input  logic                                req_start_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [salsa20_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                                csr_wr_en,
   input  logic [salsa20_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [salsa20_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   salsa20_pkg::top_state_type state_ff;
   salsa20_pkg::top_state_type state_in;

   logic [salsa20_pkg::CSR_DATA_W-1:0] key0_ff, key1_ff, key2_ff, key3_ff, nonce_ff;
   logic [salsa20_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [salsa20_pkg::COUNTER_W-1:0]  cnt_ff, cnt_in;
   logic [salsa20_pkg::BYTE_W-1:0]     msg_ff, msg_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [salsa20_pkg::BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;

   logic                               req_accept;
   logic                               out_free;
   logic [salsa20_pkg::POS_W-1:0]      eff_pos;
   logic [salsa20_pkg::COUNTER_W-1:0]  eff_cnt;
   logic [salsa20_pkg::WORD_W-1:0]     ks_word;
   logic [salsa20_pkg::BYTE_W-1:0]     ks_byte;
   logic                               gen_start;
   logic                               gen_done;

   logic [salsa20_pkg::NUM_WORDS-1:0][salsa20_pkg::WORD_W-1:0] init_words;
   logic [salsa20_pkg::NUM_WORDS-1:0][salsa20_pkg::WORD_W-1:0] ks_words;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != salsa20_pkg::ST_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;
   assign eff_pos    = req_start_req ? '0 : pos_ff;
   assign eff_cnt    = req_start_req ? '0 : cnt_ff;
   assign gen_start  = req_accept && (eff_pos == '0);

   assign ks_word = ks_words[pos_ff[salsa20_pkg::POS_W-1:2]];
   assign ks_byte = salsa20_pkg::BYTE_W'(ks_word >> {pos_ff[1:0], 3'b000});

   assign init_words[0]  = salsa20_pkg::SIGMA0;
   assign init_words[1]  = key0_ff[31:0];
   assign init_words[2]  = key0_ff[63:32];
   assign init_words[3]  = key1_ff[31:0];
   assign init_words[4]  = key1_ff[63:32];
   assign init_words[5]  = salsa20_pkg::SIGMA1;
   assign init_words[6]  = nonce_ff[31:0];
   assign init_words[7]  = nonce_ff[63:32];
   assign init_words[8]  = cnt_ff[31:0];
   assign init_words[9]  = cnt_ff[63:32];
   assign init_words[10] = salsa20_pkg::SIGMA2;
   assign init_words[11] = key2_ff[31:0];
   assign init_words[12] = key2_ff[63:32];
   assign init_words[13] = key3_ff[31:0];
   assign init_words[14] = key3_ff[63:32];
   assign init_words[15] = salsa20_pkg::SIGMA3;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salsa20_pkg::ST_IDLE: begin
            if (gen_start) begin
               state_in = salsa20_pkg::ST_GEN;
            end
         end
         salsa20_pkg::ST_GEN: begin
            if (gen_done) begin
               state_in = salsa20_pkg::ST_OUT;
            end
         end
         salsa20_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = salsa20_pkg::ST_IDLE;
            end
         end
         default: state_in = salsa20_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      msg_in       = msg_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         salsa20_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (eff_pos == '0) begin
                  msg_in = req_msg_byte;
                  cnt_in = eff_cnt;
                  pos_in = '0;
               end else begin
                  rsp_byte_in  = req_msg_byte ^ ks_byte;
                  rsp_valid_in = 1'b1;
                  pos_in       = pos_ff + 1'b1;
               end
            end
         end
         salsa20_pkg::ST_GEN: begin
            if (gen_done) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         salsa20_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_byte_in  = msg_ff ^ ks_byte;
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salsa20_pkg::ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         key0_ff      <= '0;
         key1_ff      <= '0;
         key2_ff      <= '0;
         key3_ff      <= '0;
         nonce_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               salsa20_pkg::CSR_KEY_0_7:   key0_ff  <= csr_wdata;
               salsa20_pkg::CSR_KEY_8_15:  key1_ff  <= csr_wdata;
               salsa20_pkg::CSR_KEY_16_23: key2_ff  <= csr_wdata;
               salsa20_pkg::CSR_KEY_24_31: key3_ff  <= csr_wdata;
               salsa20_pkg::CSR_NONCE:     nonce_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      msg_ff      <= msg_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   salsa20_blockgen u_blockgen (
      .clock      (clock),
      .reset      (reset),
      .gen_start  (gen_start),
      .init_words (init_words),
      .gen_done   (gen_done),
      .ks_words   (ks_words)
   );

endmodule
